@@ src/text_to_integer_parser_macros.svh @@
// Assertion macros for the text-to-integer parser.
// Included by the modules that carry concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef TEXT_TO_INTEGER_PARSER_MACROS_SVH
`define TEXT_TO_INTEGER_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define TIP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TIP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/tip_pkg.sv @@
// Shared types, constants and character helpers for the text-to-integer parser.
// No dependencies; imported by tip_step and text_to_integer_parser.
`default_nettype none

package tip_pkg;

    localparam int VALUE_BITS = 32;
    localparam int MAX_LENGTH = 4095;

    localparam int CHAR_W      = 8;
    localparam int RADIX_W     = 6;
    localparam int PHASE_W     = 3;
    localparam int POS_W       = $clog2(MAX_LENGTH + 1);
    localparam int OUT_VALUE_W = 32;
    localparam int END_W       = 12;
    localparam int PROD_W      = VALUE_BITS + RADIX_W + 1;
    localparam int OUT_TDATA_W = ((OUT_VALUE_W + END_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 2;

    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] BASE_OCT    = RADIX_W'(8);
    localparam logic [RADIX_W-1:0] BASE_DEC    = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] BASE_HEX    = RADIX_W'(16);
    localparam logic [RADIX_W-1:0] BASE_MIN    = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] BASE_MAX    = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] NO_DIGIT    = RADIX_W'(36);

    // Parse phases.
    localparam logic [PHASE_W-1:0] PH_SKIP   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SIGN   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ZERO   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_PREFIX = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DIGITS = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DONE   = 3'd5;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_A_LOWER = 8'h61;
    localparam logic [CHAR_W-1:0] CH_Z_LOWER = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_X_LOWER = 8'h78;
    localparam logic [CHAR_W-1:0] CASE_BIT   = 8'h20;
    localparam logic [CHAR_W-1:0] ASCII_MAX  = 8'h7F;

    typedef struct packed {
        logic [VALUE_BITS-1:0] magnitude;
        logic [PHASE_W-1:0]    phase;
        logic                  negative;
        logic                  seen_digit;
        logic                  overflowed;
        logic [RADIX_W-1:0]    base;
        logic [POS_W-1:0]      position;
        logic                  given;
    } t_parse_state;

    typedef struct packed {
        logic signed [OUT_VALUE_W-1:0] value;
        logic [END_W-1:0]              end_index;
        logic                          digits_found;
        logic                          range_error;
    } t_result;

    localparam t_parse_state PARSE_RESET = '{
        magnitude:  '0,
        phase:      PH_SKIP,
        negative:   1'b0,
        seen_digit: 1'b0,
        overflowed: 1'b0,
        base:       '0,
        position:   '0,
        given:      1'b0
    };

    // Digit value of a character, NO_DIGIT where it is no digit at all.
    function automatic logic [RADIX_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] lc;
        lc = c | CASE_BIT;
        if (c > ASCII_MAX) begin
            return NO_DIGIT;
        end else if (c inside {[CH_ZERO:CH_NINE]}) begin
            return RADIX_W'(c - CH_ZERO);
        end else if (lc inside {[CH_A_LOWER:CH_Z_LOWER]}) begin
            return RADIX_W'(lc - CH_A_LOWER) + BASE_DEC;
        end else begin
            return NO_DIGIT;
        end
    endfunction

    function automatic logic usable(input logic [RADIX_W-1:0] d,
                                    input logic [RADIX_W-1:0] base);
        return (base >= BASE_MIN) && (base <= BASE_MAX) && (d < base);
    endfunction

endpackage

`default_nettype wire

@@ src/tip_step.sv @@
// Single-character step of the parser: next parse state and the result word it may give.
// Pure combinational logic; depends on tip_pkg.
`default_nettype none

module tip_step (
    input  tip_pkg::t_parse_state        i_st,
    input  logic [tip_pkg::CHAR_W-1:0]   i_char,
    input  logic                         i_last,
    input  logic [tip_pkg::RADIX_W-1:0]  i_radix,
    output tip_pkg::t_parse_state        o_st,
    output logic                         o_emit,
    output tip_pkg::t_result             o_res
);
    import tip_pkg::*;

    localparam logic [VALUE_BITS-1:0] HALF = VALUE_BITS'(1) << (VALUE_BITS - 1);

    t_parse_state                  nx;
    logic [POS_W-1:0]              p;
    logic [POS_W-1:0]              p_inc;
    logic [POS_W-1:0]              end_v;
    logic [RADIX_W-1:0]            d;
    logic                          prefix_ok;
    logic                          is_space;
    logic                          acc;
    logic                          emit_now;
    logic [PROD_W-1:0]             prod;
    logic [VALUE_BITS-1:0]         limit;
    logic signed [VALUE_BITS-1:0]  v;

    assign p         = i_st.position;
    assign p_inc     = (p == POS_W'(MAX_LENGTH)) ? p : p + 1'b1;
    assign d         = digit_value(i_char);
    assign prefix_ok = (i_radix == '0) || (i_radix == BASE_HEX);
    assign is_space  = (i_char == CH_SPACE) || (i_char inside {[CH_TAB:CH_CR]});

    always_comb begin
        nx       = i_st;
        acc      = 1'b0;
        emit_now = 1'b0;
        end_v    = '0;
        prod     = '0;
        limit    = '0;
        v        = '0;

        case (i_st.phase)
            PH_SKIP, PH_SIGN: begin
                if (i_st.phase == PH_SKIP && is_space) begin
                    // hold: leading whitespace
                end else if (i_st.phase == PH_SKIP &&
                             (i_char == CH_PLUS || i_char == CH_MINUS)) begin
                    nx.negative = (i_char == CH_MINUS);
                    nx.phase    = PH_SIGN;
                end else begin
                    if (i_radix == '0) begin
                        nx.base = (i_char == CH_ZERO) ? BASE_OCT : BASE_DEC;
                    end else begin
                        nx.base = i_radix;
                    end
                    if (i_char == CH_ZERO && prefix_ok) begin
                        acc      = 1'b1;
                        nx.phase = PH_ZERO;
                    end else if (usable(d, nx.base)) begin
                        acc      = 1'b1;
                        nx.phase = PH_DIGITS;
                    end else begin
                        emit_now = 1'b1;
                    end
                end
            end
            PH_ZERO: begin
                if ((i_char | CASE_BIT) == CH_X_LOWER && prefix_ok) begin
                    nx.base  = BASE_HEX;
                    nx.phase = PH_PREFIX;
                end else if (usable(d, i_st.base)) begin
                    acc      = 1'b1;
                    nx.phase = PH_DIGITS;
                end else begin
                    emit_now = 1'b1;
                    end_v    = p;
                end
            end
            PH_PREFIX: begin
                if (usable(d, i_st.base)) begin
                    acc      = 1'b1;
                    nx.phase = PH_DIGITS;
                end else begin
                    // the '0' alone was the number
                    emit_now = 1'b1;
                    end_v    = (p != '0) ? p - 1'b1 : '0;
                end
            end
            PH_DIGITS: begin
                if (!usable(d, i_st.base)) begin
                    emit_now = 1'b1;
                    end_v    = p;
                end else begin
                    acc = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // Multiply-add with a saturation check against the signed limit.
        limit = nx.negative ? HALF : HALF - 1'b1;
        prod  = PROD_W'(nx.magnitude) * PROD_W'(nx.base) + PROD_W'(d);
        if (acc) begin
            nx.seen_digit = 1'b1;
            if (!nx.overflowed && nx.base != '0) begin
                if (prod > PROD_W'(limit)) begin
                    nx.overflowed = 1'b1;
                end else begin
                    nx.magnitude = prod[VALUE_BITS-1:0];
                end
            end
        end

        if (emit_now) begin
            nx.given = 1'b1;
            nx.phase = PH_DONE;
        end

        nx.position = p_inc;

        // Last character closes any open number.
        o_emit = emit_now;
        if (i_last && !nx.given) begin
            o_emit = 1'b1;
            if (nx.phase == PH_ZERO || nx.phase == PH_DIGITS) begin
                end_v = p_inc;
            end else if (nx.phase == PH_PREFIX) begin
                end_v = p;
            end else begin
                end_v = '0;
            end
        end

        if (nx.overflowed) begin
            v = nx.negative ? HALF : HALF - 1'b1;
        end else begin
            v = nx.negative ? VALUE_BITS'(0) - nx.magnitude : nx.magnitude;
        end

        o_res.value        = nx.seen_digit ? OUT_VALUE_W'(v) : '0;
        o_res.end_index    = nx.seen_digit ? END_W'(end_v) : '0;
        o_res.digits_found = nx.seen_digit;
        o_res.range_error  = nx.seen_digit && nx.overflowed;

        o_st = i_last ? PARSE_RESET : nx;
    end

endmodule

`default_nettype wire

@@ src/text_to_integer_parser.sv @@
// Top level of the streaming text-to-integer parser: handshake, input and result registers.
// Depends on tip_pkg, tip_step and text_to_integer_parser_macros.svh.
//
// Usage:
//   s_axis carries one text byte per word (tdata = character code, tlast marks the
//   final byte of a string). m_axis carries one result word per string: the signed
//   value and end position in tdata, the digits-found and range-error flags in tuser.
//   A result word appears when the number ends (first byte that is no digit) or at
//   the tlast byte, whichever comes first; later bytes up to tlast give nothing.
//   The cfg channel writes the radix (0 = detect from prefix, 2..36); it is always
//   ready and must only be written while the parser is idle.
// Timing:
//   A byte lands in an input register, is parsed by one multiply-add (32 x 6 bits)
//   and compare once the result register is free, and the result is registered in
//   the output register. One byte per cycle is sustained while m_axis_tready stays
//   high; the parse state loop through that multiply-add sets the rate.
// Reset and stall:
//   Synchronous active-low reset clears the parse state, empties both registers and
//   sets the radix to 10. While m_axis_tready is low with a result waiting, the byte
//   in the input register holds and s_axis_tready drops; bytes that give no result
//   still advance when the result register is free.
`default_nettype none
`include "text_to_integer_parser_macros.svh"

module text_to_integer_parser (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // radix write
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tip_pkg::RADIX_W-1:0]        i_cfg_data,
    // text in
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [tip_pkg::CHAR_W-1:0]         s_axis_tdata,   // [7:0] char_code
    input  logic                               s_axis_tlast,
    // results out
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [tip_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [31:0] parsed_value,
                                                               // [43:32] end_index, rest 0
    output logic [tip_pkg::OUT_TUSER_W-1:0]    m_axis_tuser    // [0] digits_found,
                                                               // [1] range_error
);
    import tip_pkg::*;

    logic               r_in_valid;
    logic [CHAR_W-1:0]  r_in_char;
    logic               r_in_last;
    logic [RADIX_W-1:0] r_radix;
    t_parse_state       r_st;
    logic               r_out_valid;
    t_result            r_out;

    t_parse_state       n_st;
    t_result            n_out;
    logic               step_emit;
    logic               out_free;
    logic               step_go;
    logic               in_take;

    tip_step u_step (
        .i_st    (r_st),
        .i_char  (r_in_char),
        .i_last  (r_in_last),
        .i_radix (r_radix),
        .o_st    (n_st),
        .o_emit  (step_emit),
        .o_res   (n_out)
    );

    // Advance the byte in the input register whenever the result register can take a word.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign step_go       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || step_go;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_radix     <= RADIX_RESET;
            r_st        <= PARSE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_radix <= i_cfg_data;
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (step_go) begin
                r_in_valid <= 1'b0;
            end
            if (step_go) begin
                r_st <= n_st;
            end
            if (step_go && step_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (step_go && step_emit) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - OUT_VALUE_W - END_W)'(0),
                            r_out.end_index, r_out.value};
    assign m_axis_tuser  = {r_out.range_error, r_out.digits_found};

    `TIP_ASSERT_NEXT(a_last_clears, step_go && r_in_last, r_st.phase == PH_SKIP && !r_st.given && !r_st.seen_digit, "parse state not cleared after last byte")
    `TIP_ASSERT_IMPLY(a_given_done, r_st.given, r_st.phase == PH_DONE, "result given outside done phase")
    `TIP_ASSERT_IMPLY(a_range_digits, r_out_valid && r_out.range_error, r_out.digits_found, "range error without digits")
    `TIP_ASSERT_IMPLY(a_empty_zero, r_out_valid && !r_out.digits_found, r_out.value == '0 && r_out.end_index == '0, "no-digit result not zero")
    `TIP_ASSERT_NEXT(a_out_hold, r_out_valid && !m_axis_tready, r_out_valid && $stable(r_out), "waiting result word changed")

endmodule

`default_nettype wire
